[src/broadcast_gather_index_unit_defines.svh]
// shared assertion macros
`ifndef BROADCAST_GATHER_INDEX_UNIT_DEFINES_SVH
`define BROADCAST_GATHER_INDEX_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BGI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgi check failed");

// antecedent implies consequent in the next cycle
`define BGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgi check failed");

`endif

[src/bgi_pkg.sv]
`default_nettype none

package bgi_pkg;

    typedef struct packed {
        logic valid;
        logic inr;
    } ctl_t;

    localparam int ADDR_BITS = 5;

    localparam logic [1:0] REG_SOURCE_DIMS = 2'd0;
    localparam logic [1:0] REG_SOURCE_RANK = 2'd1;
    localparam logic [1:0] REG_TARGET_DIMS = 2'd2;
    localparam logic [1:0] REG_TARGET_RANK = 2'd3;

endpackage

`default_nettype wire

[src/broadcast_gather_index_unit.sv]
// throughput: one transaction per cycle while busy is low, set by a row of one-bit divide cells per axis
// reset: the configuration registers clear to zero; busy is high after reset
// and after every register write while the stride tables are rebuilt
// results come out on done for one cycle; the receiver cannot stall
`default_nettype none

module broadcast_gather_index_unit #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [31:0]                   out_index,
    output logic                               done,
    output logic [31:0]                        src_offset,
    output logic                               in_range,
    output logic [31:0]                        out_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bgi_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    `include "broadcast_gather_index_unit_defines.svh"

    localparam int W  = INDEX_BITS;
    localparam int DB = DIM_BITS;
    localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CW = $clog2(MAX_RANK + 1);
    localparam int MW = (W > 32) ? W : 32;

    logic [63:0]   src_dims_reg;
    logic [2:0]    src_rank_reg;
    logic [63:0]   tgt_dims_reg;
    logic [2:0]    tgt_rank_reg;

    logic          deriving_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_src_reg;
    logic [W-1:0]  acc_out_reg;
    logic [W-1:0]  total_reg;
    logic [W-1:0]  out_stride_reg [MAX_RANK];
    logic [W-1:0]  src_stride_reg [MAX_RANK];
    logic [DB-1:0] origin_reg     [MAX_RANK];
    logic [DB-1:0] last_reg       [MAX_RANK];

    logic [DB-1:0] src_f [MAX_RANK];
    logic [DB-1:0] tgt_f [MAX_RANK];

    logic          cfg_wr;
    logic [AW-1:0] j;
    logic [31:0]   sr_sat, tr_sat;
    logic [DB-1:0] pin, tv, od;
    logic [W+DB-1:0] prod_src, prod_out;
    logic [W-1:0]  acc_src_next, acc_out_next;
    logic          accept;

    genvar g, k;

    generate
        for (g = 0; g < MAX_RANK; g++)
        begin : g_field
            assign src_f[g] = DB'(src_dims_reg >> (g * DB));
            assign tgt_f[g] = DB'(tgt_dims_reg >> (g * DB));
        end
    endgenerate

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:3])
            bgi_pkg::REG_SOURCE_DIMS: prdata = src_dims_reg;
            bgi_pkg::REG_SOURCE_RANK: prdata = 64'(src_rank_reg);
            bgi_pkg::REG_TARGET_DIMS: prdata = tgt_dims_reg;
            bgi_pkg::REG_TARGET_RANK: prdata = 64'(tgt_rank_reg);
            default:                  prdata = '0;
        endcase
    end

    // table build, one axis per cycle
    always_comb
    begin
        j      = cnt_reg[AW-1:0];
        sr_sat = (32'(src_rank_reg) > MAX_RANK) ? 32'(MAX_RANK) : 32'(src_rank_reg);
        tr_sat = (32'(tgt_rank_reg) > MAX_RANK) ? 32'(MAX_RANK) : 32'(tgt_rank_reg);
        pin    = (32'(cnt_reg) < sr_sat) ? src_f[j] : DB'(1);
        tv     = DB'(1);
        if ((32'(cnt_reg) < tr_sat) && !tgt_f[j][DB-1])
        begin
            tv = tgt_f[j];
        end
        od       = (pin > tv) ? pin : tv;
        prod_src = {{DB{1'b0}}, acc_src_reg} * {{W{1'b0}}, pin};
        prod_out = {{DB{1'b0}}, acc_out_reg} * {{W{1'b0}}, od};
        acc_src_next = (prod_src[W+DB-1:W] != '0) ? '1 : prod_src[W-1:0];
        acc_out_next = (prod_out[W+DB-1:W] != '0) ? '1 : prod_out[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_dims_reg <= '0;
            src_rank_reg <= '0;
            tgt_dims_reg <= '0;
            tgt_rank_reg <= '0;
            deriving_reg <= 1'b1;
            cnt_reg      <= '0;
            acc_src_reg  <= W'(1);
            acc_out_reg  <= W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                bgi_pkg::REG_SOURCE_DIMS: src_dims_reg <= pwdata;
                bgi_pkg::REG_SOURCE_RANK: src_rank_reg <= pwdata[2:0];
                bgi_pkg::REG_TARGET_DIMS: tgt_dims_reg <= pwdata;
                bgi_pkg::REG_TARGET_RANK: tgt_rank_reg <= pwdata[2:0];
                default:                  ;
            endcase
            deriving_reg <= 1'b1;
            cnt_reg      <= '0;
            acc_src_reg  <= W'(1);
            acc_out_reg  <= W'(1);
        end
        else if (deriving_reg)
        begin
            acc_src_reg <= acc_src_next;
            acc_out_reg <= acc_out_next;
            cnt_reg     <= cnt_reg + CW'(1);
            if (32'(cnt_reg) == MAX_RANK - 1)
            begin
                deriving_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (deriving_reg && !cfg_wr)
        begin
            src_stride_reg[j] <= acc_src_reg;
            out_stride_reg[j] <= acc_out_reg;
            origin_reg[j]     <= od - pin;
            last_reg[j]       <= (pin != '0) ? (pin - DB'(1)) : '0;
            total_reg         <= acc_out_next;
        end
    end

    assign busy   = deriving_reg;
    assign accept = start && !busy;

    // axis chain, top axis first
    bgi_pkg::ctl_t ax_ctl [MAX_RANK+1];
    logic [W-1:0]  ax_rem [MAX_RANK+1];
    logic [W-1:0]  ax_off [MAX_RANK+1];
    bgi_pkg::ctl_t d_ctl  [MAX_RANK][W+1];
    logic [W-1:0]  d_rem  [MAX_RANK][W+1];
    logic [W-1:0]  d_q    [MAX_RANK][W+1];
    logic [W-1:0]  d_off  [MAX_RANK][W+1];

    assign ax_ctl[0].valid = accept;
    assign ax_ctl[0].inr   = MW'(out_index) < MW'(total_reg);
    assign ax_rem[0]       = W'(out_index);
    assign ax_off[0]       = '0;

    generate
        for (g = 0; g < MAX_RANK; g++)
        begin : g_axis
            assign d_ctl[g][0] = ax_ctl[g];
            assign d_rem[g][0] = ax_rem[g];
            assign d_q[g][0]   = '0;
            assign d_off[g][0] = ax_off[g];

            for (k = 0; k < W; k++)
            begin : g_bit
                bgi_div_cell #(
                    .W     (W),
                    .SHIFT (W - 1 - k)
                ) u_div (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctl_in  (d_ctl[g][k]),
                    .rem_in  (d_rem[g][k]),
                    .q_in    (d_q[g][k]),
                    .off_in  (d_off[g][k]),
                    .stride  (out_stride_reg[MAX_RANK-1-g]),
                    .ctl_out (d_ctl[g][k+1]),
                    .rem_out (d_rem[g][k+1]),
                    .q_out   (d_q[g][k+1]),
                    .off_out (d_off[g][k+1])
                );
            end

            bgi_axis_cell #(
                .W  (W),
                .DB (DB)
            ) u_axis (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl_in  (d_ctl[g][W]),
                .rem_in  (d_rem[g][W]),
                .q_in    (d_q[g][W]),
                .off_in  (d_off[g][W]),
                .origin  (origin_reg[MAX_RANK-1-g]),
                .last    (last_reg[MAX_RANK-1-g]),
                .sstride (src_stride_reg[MAX_RANK-1-g]),
                .ctl_out (ax_ctl[g+1]),
                .rem_out (ax_rem[g+1]),
                .off_out (ax_off[g+1])
            );
        end
    endgenerate

    assign done       = ax_ctl[MAX_RANK].valid;
    assign in_range   = ax_ctl[MAX_RANK].inr;
    assign src_offset = ax_ctl[MAX_RANK].inr ? 32'(ax_off[MAX_RANK]) : 32'd0;
    assign out_count  = 32'(total_reg);

    `BGI_ASSERT_NEXT(a_busy_after_write, clk, rst_n, cfg_wr, busy)
    `BGI_ASSERT_NOW(a_no_accept_while_deriving, clk, rst_n, deriving_reg, !accept)
    `BGI_ASSERT_NOW(a_out_of_range_zero, clk, rst_n, done && !in_range, src_offset == 32'd0)

endmodule

`default_nettype wire

[src/bgi_div_cell.sv]
`default_nettype none

// one restoring division step: quotient bit for weight 2^SHIFT
module bgi_div_cell #(
    parameter int W     = 32,
    parameter int SHIFT = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bgi_pkg::ctl_t ctl_in,
    input  wire logic [W-1:0]  rem_in,
    input  wire logic [W-1:0]  q_in,
    input  wire logic [W-1:0]  off_in,
    input  wire logic [W-1:0]  stride,
    output bgi_pkg::ctl_t      ctl_out,
    output logic [W-1:0]       rem_out,
    output logic [W-1:0]       q_out,
    output logic [W-1:0]       off_out
);

    logic [2*W-1:0] big;
    logic           ge;
    bgi_pkg::ctl_t  ctl_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   q_reg;
    logic [W-1:0]   off_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   q_next;

    always_comb
    begin
        big      = {{W{1'b0}}, stride} << SHIFT;
        // zero stride means no split on this axis
        ge       = (stride != '0) && ({{W{1'b0}}, rem_in} >= big);
        rem_next = ge ? (rem_in - big[W-1:0]) : rem_in;
        q_next   = (q_in << 1) | W'(ge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        off_reg <= off_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign off_out = off_reg;

endmodule

`default_nettype wire

[src/bgi_axis_cell.sv]
`default_nettype none

// clamp coordinate into source extent, scale by source stride, accumulate
module bgi_axis_cell #(
    parameter int W  = 32,
    parameter int DB = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bgi_pkg::ctl_t ctl_in,
    input  wire logic [W-1:0]  rem_in,
    input  wire logic [W-1:0]  q_in,
    input  wire logic [W-1:0]  off_in,
    input  wire logic [DB-1:0] origin,
    input  wire logic [DB-1:0] last,
    input  wire logic [W-1:0]  sstride,
    output bgi_pkg::ctl_t      ctl_out,
    output logic [W-1:0]       rem_out,
    output logic [W-1:0]       off_out
);

    localparam int XW = (W > DB) ? W : DB;

    logic [XW-1:0]   q_x;
    logic [XW-1:0]   org_x;
    logic [XW-1:0]   last_x;
    logic [XW-1:0]   sh;
    logic [DB-1:0]   s_next;
    logic [W-1:0]    term;
    logic [W:0]      sum;
    logic [W-1:0]    off_next;

    bgi_pkg::ctl_t   ctl1_reg, ctl2_reg, ctl3_reg;
    logic [W-1:0]    rem1_reg, rem2_reg, rem3_reg;
    logic [W-1:0]    off1_reg, off2_reg, off3_reg;
    logic [DB-1:0]   s_reg;
    logic [W+DB-1:0] prod_reg;

    always_comb
    begin
        q_x    = XW'(q_in);
        org_x  = XW'(origin);
        last_x = XW'(last);
        sh     = (q_x < org_x) ? '0 : (q_x - org_x);
        s_next = (sh > last_x) ? last : DB'(sh);
        term   = (prod_reg[W+DB-1:W] != '0) ? '1 : prod_reg[W-1:0];
        sum    = {1'b0, off2_reg} + {1'b0, term};
        off_next = sum[W] ? '1 : sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        rem1_reg <= rem_in;
        off1_reg <= off_in;
        prod_reg <= {{W{1'b0}}, s_reg} * {{DB{1'b0}}, sstride};
        rem2_reg <= rem1_reg;
        off2_reg <= off1_reg;
        rem3_reg <= rem2_reg;
        off3_reg <= off_next;
    end

    assign ctl_out = ctl3_reg;
    assign rem_out = rem3_reg;
    assign off_out = off3_reg;

endmodule

`default_nettype wire

[tb/bgi_checker.sv]
`default_nettype none

module bgi_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [31:0]                   out_index,
    input  wire logic                          done,
    input  wire logic [31:0]                   src_offset,
    input  wire logic                          in_range,
    input  wire logic [31:0]                   out_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bgi_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]                   pwdata,
    input  wire logic                          pready,
    output int                                 fail_count,
    output int                                 pending,
    output logic [63:0]                        elem_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAXES = 4;
    localparam longint unsigned IDX_LIMIT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] src_offset;
        logic        in_range;
        logic [31:0] out_count;
    } gather_addr_t;

    logic [63:0] src_dims_q;
    logic [2:0]  src_rank_q;
    logic [63:0] tgt_dims_q;
    logic [2:0]  tgt_rank_q;

    longint unsigned ostride[NAXES];
    longint unsigned sstride[NAXES];
    longint unsigned origin[NAXES];
    longint unsigned last_coord[NAXES];
    longint unsigned count_q;

    gather_addr_t addr_q[$];

    function automatic longint unsigned mul_clip(longint unsigned a, longint unsigned b);
        if (b != 0 && a > IDX_LIMIT / b)
            return IDX_LIMIT;
        return a * b;
    endfunction

    function automatic void rebuild_strides();
        longint unsigned sr;
        longint unsigned tr;
        longint unsigned acc_s;
        longint unsigned acc_o;
        longint unsigned pin;
        longint unsigned t;
        longint unsigned od;
        sr = (src_rank_q > NAXES) ? NAXES : src_rank_q;
        tr = (tgt_rank_q > NAXES) ? NAXES : tgt_rank_q;
        acc_s = 1;
        acc_o = 1;
        for (int j = 0; j < NAXES; j++)
        begin
            pin = (j < sr) ? longint'(src_dims_q[j*16 +: 16]) : 1;
            t = 1;
            if (j < tr)
            begin
                t = longint'(tgt_dims_q[j*16 +: 16]);
                // negative target dim behaves as one
                if (tgt_dims_q[j*16 + 15])
                    t = 1;
            end
            od = (pin > t) ? pin : t;
            sstride[j] = acc_s;
            ostride[j] = acc_o;
            origin[j] = od - pin;
            last_coord[j] = (pin != 0) ? pin - 1 : 0;
            acc_s = mul_clip(acc_s, pin);
            acc_o = mul_clip(acc_o, od);
        end
        count_q = acc_o;
    endfunction

    function automatic gather_addr_t gather_address(logic [31:0] idx);
        gather_addr_t r;
        longint unsigned rem;
        longint unsigned c;
        longint unsigned s;
        longint unsigned term;
        longint unsigned off;
        off = 0;
        rem = idx;
        r.in_range = (longint'(idx) < count_q);
        if (r.in_range)
        begin
            for (int j = NAXES - 1; j >= 0; j--)
            begin
                c = 0;
                if (ostride[j] != 0)
                begin
                    c = rem / ostride[j];
                    rem = rem % ostride[j];
                end
                s = (c < origin[j]) ? 0 : c - origin[j];
                if (s > last_coord[j])
                    s = last_coord[j];
                term = mul_clip(s, sstride[j]);
                off = (term > IDX_LIMIT - off) ? IDX_LIMIT : off + term;
            end
        end
        r.src_offset = off[31:0];
        r.out_count = count_q[31:0];
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        src_dims_q = '0;
        src_rank_q = '0;
        tgt_dims_q = '0;
        tgt_rank_q = '0;
        rebuild_strides();
    end

    assign pending = addr_q.size();
    assign elem_total = count_q;

    always @(posedge clk or negedge rst_n)
    begin
        gather_addr_t e;
        if (!rst_n)
        begin
            src_dims_q = '0;
            src_rank_q = '0;
            tgt_dims_q = '0;
            tgt_rank_q = '0;
            rebuild_strides();
            addr_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (addr_q.size() == 0)
                begin
                    $error("unexpected result transaction: src_offset %0h", src_offset);
                    fail_count++;
                end
                else
                begin
                    e = addr_q.pop_front();
                    if (src_offset !== e.src_offset)
                    begin
                        $error("src_offset expected %0h actual %0h", e.src_offset, src_offset);
                        fail_count++;
                    end
                    if (in_range !== e.in_range)
                    begin
                        $error("in_range expected %0b actual %0b", e.in_range, in_range);
                        fail_count++;
                    end
                    if (out_count !== e.out_count)
                    begin
                        $error("out_count expected %0h actual %0h", e.out_count, out_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                addr_q.push_back(gather_address(out_index));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:3])
                    bgi_pkg::REG_SOURCE_DIMS: src_dims_q = pwdata;
                    bgi_pkg::REG_SOURCE_RANK: src_rank_q = pwdata[2:0];
                    bgi_pkg::REG_TARGET_DIMS: tgt_dims_q = pwdata;
                    bgi_pkg::REG_TARGET_RANK: tgt_rank_q = pwdata[2:0];
                    default: ;
                endcase
                rebuild_strides();
            end
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [31:0]                   out_index;
    logic                          done;
    logic [31:0]                   src_offset;
    logic                          in_range;
    logic [31:0]                   out_count;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bgi_pkg::ADDR_BITS-1:0] paddr;
    logic [63:0]                   pwdata;
    logic [63:0]                   prdata;
    logic                          pready;

    int          fail_count;
    int          pending;
    logic [63:0] elem_total;
    int          idle_pct;
    int          cycles;

    broadcast_gather_index_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_index(out_index),
        .done(done), .src_offset(src_offset), .in_range(in_range), .out_count(out_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bgi_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_index(out_index),
        .done(done), .src_offset(src_offset), .in_range(in_range), .out_count(out_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending),
        .elem_total(elem_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // drain the pipeline, then write one register through a setup and access phase
    task automatic reg_write(logic [1:0] reg_idx, logic [63:0] value);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic issue(logic [31:0] idx);
        start <= 1'b1;
        out_index <= idx;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 | 16'($urandom);
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 9));
        endcase
    endfunction

    function automatic logic [63:0] pick_dims();
        if ($urandom_range(0, 15) == 0)
            return {$urandom, $urandom};
        return {pick_dim(), pick_dim(), pick_dim(), pick_dim()};
    endfunction

    function automatic logic [31:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (elem_total != 0 && r < 65)
            return 32'(64'($urandom) % elem_total);
        if (r < 75)
            return 32'(elem_total + 64'($urandom_range(0, 2)) - 64'd1);
        return $urandom;
    endfunction

    task automatic edge_indexes();
        issue(32'h0);
        issue(32'(elem_total - 1));
        issue(32'(elem_total));
        issue(32'hFFFF_FFFF);
    endtask

    initial
    begin
        int sent;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        out_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 18;
        sent = 0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        // reset shape: every axis is one
        edge_indexes();
        issue(32'h1);

        // three-axis source into a four-axis target with a negative axis
        reg_write(bgi_pkg::REG_SOURCE_DIMS, 64'h0000_0003_0001_0004);
        reg_write(bgi_pkg::REG_SOURCE_RANK, 64'd3);
        reg_write(bgi_pkg::REG_TARGET_DIMS, 64'h0002_0003_FFFF_0004);
        reg_write(bgi_pkg::REG_TARGET_RANK, 64'd4);
        edge_indexes();
        for (int k = 0; k < 6; k++)
            issue(32'(k * 5));

        // zero source dim, empty output when target also zero on that axis
        reg_write(bgi_pkg::REG_SOURCE_DIMS, 64'h0000_0000_0002_0000);
        reg_write(bgi_pkg::REG_TARGET_DIMS, 64'h0000_0000_0002_0000);
        reg_write(bgi_pkg::REG_TARGET_RANK, 64'd2);
        edge_indexes();

        // saturating products, ranks above the axis count
        reg_write(bgi_pkg::REG_SOURCE_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(bgi_pkg::REG_SOURCE_RANK, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(bgi_pkg::REG_TARGET_DIMS, 64'h7FFF_7FFF_7FFF_7FFF);
        reg_write(bgi_pkg::REG_TARGET_RANK, 64'd7);
        edge_indexes();
        issue(32'h8000_0000);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 18 : (ph == 1) ? 72 : 0;
            for (int c = 0; c < 7; c++)
            begin
                reg_write(bgi_pkg::REG_SOURCE_DIMS, pick_dims());
                reg_write(bgi_pkg::REG_SOURCE_RANK, {$urandom, $urandom});
                reg_write(bgi_pkg::REG_TARGET_DIMS, pick_dims());
                reg_write(bgi_pkg::REG_TARGET_RANK, {$urandom, $urandom});
                n = $urandom_range(35, 55);
                for (int k = 0; k < n; k++)
                    issue(pick_index());
                sent += n;
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/bgi_pkg.sv
src/bgi_div_cell.sv
src/bgi_axis_cell.sv
src/broadcast_gather_index_unit.sv
tb/bgi_checker.sv
tb/testbench.sv
